// ===== hw/rtl/sfp_pkg.sv =====
`timescale 1ns / 1ps

package sfp_pkg;

    // Default payload store depth
    localparam int unsigned MAX_PAYLOAD_DEF = 32;

    // Frame delimiters
    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'hFE;
    localparam logic [7:0] TAIL_BYTE  = 8'hAA;

    // Fixed field and counter widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned FLEN_W = 6;

    // One result item
    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [FLEN_W-1:0] frame_length;
        logic              last;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load_len;
        logic take_data;
        logic rd_start;
        logic rd_next;
        logic load_frame;
        logic load_err;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_hdr1;
        logic is_hdr2;
        logic len_ok;
        logic data_done;
        logic sum_ok;
        logic tail_ok;
        logic res_last;
    } t_sts;

endpackage

// ===== hw/rtl/sfp_if.sv =====
`timescale 1ns / 1ps

// Received byte channel
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result item channel
interface sfp_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic [5:0] frame_length;
    logic       last;

    modport source (output valid, output status, output payload_byte, output byte_index,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input status, input payload_byte, input byte_index,
                    input frame_length, input last, output ready);
endinterface

// ===== hw/rtl/sfp_ram.sv =====
`timescale 1ns / 1ps

module sfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfp_datapath.sv =====
`timescale 1ns / 1ps

module sfp_datapath #(
    parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfp_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_rx_byte,
    output sfp_pkg::t_sts   o_sts,
    output sfp_pkg::t_result o_res
);

    localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CNT_W  = sfp_pkg::CNT_W;
    localparam int unsigned IDX_W  = sfp_pkg::IDX_W;
    localparam int unsigned FLEN_W = sfp_pkg::FLEN_W;
    localparam logic [7:0]  MAX_B  = 8'(MAX_PAYLOAD);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [LEN_W-1:0] r_exp;
    logic [7:0]       r_sum;
    logic [AW-1:0]    r_idx;
    sfp_pkg::t_result r_res;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_q;

    // Payload byte count wraps at its own width
    assign n_cnt = r_cnt + CNT_W'(1);

    // Byte classification and frame checks
    always_comb begin
        o_sts.is_hdr1   = (i_rx_byte == sfp_pkg::HDR_FIRST);
        o_sts.is_hdr2   = (i_rx_byte == sfp_pkg::HDR_SECOND);
        o_sts.len_ok    = (i_rx_byte != 8'd0) && (i_rx_byte <= MAX_B);
        o_sts.data_done = (8'(n_cnt) >= 8'(r_exp));
        o_sts.sum_ok    = (r_sum == i_rx_byte);
        o_sts.tail_ok   = (i_rx_byte == sfp_pkg::TAIL_BYTE);
        o_sts.res_last  = r_res.last;
    end

    // Store port control
    assign ram_we    = i_cmd.take_data && (8'(r_cnt) < MAX_B);
    assign ram_waddr = AW'(r_cnt);
    assign ram_re    = i_cmd.rd_start || i_cmd.rd_next;
    assign ram_raddr = i_cmd.rd_start ? '0 : AW'(r_idx + AW'(1));

    sfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Length, count and checksum accumulation; drain index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_exp <= '0;
            r_sum <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.load_len) begin
                r_exp <= LEN_W'(i_rx_byte);
                r_cnt <= '0;
                r_sum <= i_rx_byte;
            end else if (i_cmd.take_data) begin
                r_cnt <= n_cnt;
                r_sum <= r_sum + i_rx_byte;
            end
            if (i_cmd.rd_start) begin
                r_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_res.status       <= 1'b1;
            r_res.payload_byte <= '0;
            r_res.byte_index   <= '0;
            r_res.frame_length <= '0;
            r_res.last         <= 1'b1;
        end else if (i_cmd.load_frame) begin
            r_res.status       <= 1'b0;
            r_res.payload_byte <= ram_q;
            r_res.byte_index   <= IDX_W'(r_idx);
            r_res.frame_length <= FLEN_W'(r_exp);
            r_res.last         <= ((8'(r_idx) + 8'd1) == 8'(r_exp));
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/sfp_ctrl.sv =====
`timescale 1ns / 1ps

module sfp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sfp_pkg::t_sts i_sts,
    output sfp_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_HDR1,
        S_HDR2,
        S_LEN,
        S_DATA,
        S_CHK,
        S_TAIL,
        S_RD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR1;
        end else begin
            r_state <= n_state;
        end
    end

    // Parse sequence, then drain one result at a time
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_HDR1: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.is_hdr1) begin
                    n_state = S_HDR2;
                end
            end
            S_HDR2: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.is_hdr2) begin
                        n_state = S_LEN;
                    end else if (!i_sts.is_hdr1) begin
                        n_state = S_HDR1;
                    end
                end
            end
            S_LEN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.len_ok) begin
                        o_cmd.load_len = 1'b1;
                        n_state        = S_DATA;
                    end else begin
                        o_cmd.load_err = 1'b1;
                        n_state        = S_OUT;
                    end
                end
            end
            S_DATA: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_data = 1'b1;
                    if (i_sts.data_done) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.sum_ok) begin
                        n_state = S_TAIL;
                    end else begin
                        o_cmd.load_err = 1'b1;
                        n_state        = S_OUT;
                    end
                end
            end
            S_TAIL: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.tail_ok) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD;
                    end else begin
                        o_cmd.load_err = 1'b1;
                        n_state        = S_OUT;
                    end
                end
            end
            S_RD: begin
                // store data is valid now
                o_cmd.load_frame = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        n_state = S_HDR1;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HDR1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/serial_frame_parser.sv =====
`timescale 1ns / 1ps
// Order: an error item appears the cycle after the offending byte; the first payload
// item follows the tail byte via the registered store read and the output register.
// Throughput: one input byte per cycle while parsing; a frame drains one item at a time
// (registered store read, output register, wait for ready); input is held off meanwhile.
// Reset (synchronous, active low) restarts the header search and clears count, length and
// checksum; the payload store keeps its contents and needs no clearing pass.

module serial_frame_parser #(
    parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfp_in_if.sink     i_rx,
    sfp_out_if.source  o_res
);

    sfp_pkg::t_cmd    cmd;
    sfp_pkg::t_sts    sts;
    sfp_pkg::t_result res;

    sfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rx_byte (i_rx.rx_byte),
        .o_sts     (sts),
        .o_res     (res)
    );

    // Result fields onto the channel
    assign o_res.status       = res.status;
    assign o_res.payload_byte = res.payload_byte;
    assign o_res.byte_index   = res.byte_index;
    assign o_res.frame_length = res.frame_length;
    assign o_res.last         = res.last;

endmodule

// ===== hw/rtl/sfp_checker.sv =====
`timescale 1ns / 1ps

module sfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_status,
    input logic [7:0] i_payload_byte,
    input logic [4:0] i_byte_index,
    input logic [5:0] i_frame_length,
    input logic       i_last
);

    // Input is never taken while an item waits at the output
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result item is pending");

    // Error items carry zero fields and close their run
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |->
            (i_last && i_payload_byte == 8'd0 && i_byte_index == 5'd0 &&
             i_frame_length == 6'd0))
        else $error("error item with nonzero fields");

    // A frame that is not finished keeps draining, input stays held off
    a_drain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_status && !i_last) |=> !i_in_ready)
        else $error("input reopened in the middle of a frame drain");

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item valid right after reset");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_payload_byte) && $stable(i_byte_index) &&
             $stable(i_last) && $stable(i_status)))
        else $error("stalled result item changed");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_payload_byte (o_res.payload_byte),
    .i_byte_index   (o_res.byte_index),
    .i_frame_length (o_res.frame_length),
    .i_last         (o_res.last)
);

// ===== dv/tb_serial_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_serial_frame_parser;

    localparam int unsigned DEPTH       = sfp_pkg::MAX_PAYLOAD_DEF;
    localparam int unsigned IDX_BITS    = $clog2(DEPTH);
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 40;

    // Parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEEK_HDR1, SEEK_HDR2, GET_LEN, GET_DATA, GET_SUM, GET_TAIL
    } t_phase;

    // Shapes of generated traffic
    typedef enum {
        FR_GOOD, FR_BAD_LEN, FR_BAD_SUM, FR_BAD_TAIL, FR_NOISE
    } t_frame_kind;

    typedef logic [7:0] t_bytes[$];

    logic i_clk;
    logic i_rst_n;

    sfp_in_if  rx_if ();
    sfp_out_if res_if ();

    serial_frame_parser #(
        .MAX_PAYLOAD(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    // Predictor state
    t_phase           parse_phase;
    logic [7:0]       payload_copy [DEPTH];
    logic [5:0]       bytes_taken;
    logic [5:0]       frame_len;
    logic [7:0]       frame_sum;
    sfp_pkg::t_result expected_results[$];

    // Run bookkeeping
    bit               idle_en;
    int               hold_request;
    int               n_fail;
    int               bytes_sent;
    int               noise_bytes;
    int               good_frames;
    int               error_results;
    int               longest_frame;
    int               quiet_cycles;
    sfp_pkg::t_result got_res;
    sfp_pkg::t_result want_res;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected error item
    function automatic void push_frame_error();
        sfp_pkg::t_result r;
        r        = '0;
        r.status = 1'b1;
        r.last   = 1'b1;
        expected_results.push_back(r);
        parse_phase = SEEK_HDR1;
    endfunction

    // Advance the frame search by one received byte
    function automatic void parse_byte(input logic [7:0] b);
        sfp_pkg::t_result r;
        int unsigned i;
        case (parse_phase)
            SEEK_HDR1: begin
                if (b == sfp_pkg::HDR_FIRST) parse_phase = SEEK_HDR2;
            end
            SEEK_HDR2: begin
                if (b == sfp_pkg::HDR_SECOND) parse_phase = GET_LEN;
                else if (b != sfp_pkg::HDR_FIRST) parse_phase = SEEK_HDR1;
            end
            GET_LEN: begin
                if (b != 8'd0 && b <= DEPTH) begin
                    frame_len   = b[5:0];
                    bytes_taken = '0;
                    frame_sum   = b;
                    parse_phase = GET_DATA;
                end else begin
                    push_frame_error();
                end
            end
            GET_DATA: begin
                if (bytes_taken < DEPTH) payload_copy[bytes_taken[IDX_BITS-1:0]] = b;
                bytes_taken = bytes_taken + 6'd1;
                frame_sum   = frame_sum + b;
                if (bytes_taken >= frame_len) parse_phase = GET_SUM;
            end
            GET_SUM: begin
                if (frame_sum == b) parse_phase = GET_TAIL;
                else push_frame_error();
            end
            GET_TAIL: begin
                if (b == sfp_pkg::TAIL_BYTE) begin
                    // whole payload drains, last flag on the final item
                    for (i = 0; i < frame_len; i++) begin
                        r              = '0;
                        r.payload_byte = payload_copy[i[IDX_BITS-1:0]];
                        r.byte_index   = i[4:0];
                        r.frame_length = frame_len;
                        r.last         = (i + 1 == frame_len);
                        expected_results.push_back(r);
                    end
                    parse_phase = SEEK_HDR1;
                end else begin
                    push_frame_error();
                end
            end
            default: push_frame_error();
        endcase
    endfunction

    // Offer one byte, wait for acceptance, then predict
    task automatic send_byte(input logic [7:0] b);
        while (idle_en && $urandom_range(0, 99) < 10) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_bytes(input t_bytes seq);
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // Sender goes quiet until every expected item is back
    task automatic wait_results_drained();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Mostly short payloads, some long ones, the full store now and then
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return DEPTH;
        if (r < 20) return $urandom_range(9, DEPTH - 1);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_frame(input t_frame_kind kind, input int unsigned plen);
        logic [7:0] sum;
        logic [7:0] b;
        int unsigned i;
        int unsigned n;
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 6);
            noise_bytes += n;
            repeat (n) send_byte(8'($urandom));
            return;
        end
        // an extra first header byte now and then
        if ($urandom_range(0, 4) == 0) send_byte(sfp_pkg::HDR_FIRST);
        send_byte(sfp_pkg::HDR_FIRST);
        send_byte(sfp_pkg::HDR_SECOND);
        if (kind == FR_BAD_LEN) begin
            if ($urandom_range(0, 1) == 0) send_byte(8'h00);
            else send_byte(8'($urandom_range(DEPTH + 1, 255)));
            return;
        end
        sum = 8'(plen);
        send_byte(8'(plen));
        for (i = 0; i < plen; i++) begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        if (kind == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
        if (kind == FR_BAD_SUM) return;
        if (kind == FR_BAD_TAIL) send_byte(sfp_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255)));
        else send_byte(sfp_pkg::TAIL_BYTE);
    endtask

    // Boundary lengths, byte extremes and each error path
    task automatic test_directed();
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'h01, 8'hFF, 8'h00,
                     sfp_pkg::TAIL_BYTE});
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'h00});
        send_bytes('{sfp_pkg::HDR_FIRST, 8'h12});
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'(DEPTH + 1)});
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'hFF});
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'h01, 8'h55, 8'h00});
        send_bytes('{sfp_pkg::HDR_FIRST, sfp_pkg::HDR_SECOND, 8'h02, 8'h00, 8'h7F, 8'h81,
                     8'hAB});
        wait_results_drained();
    endtask

    // Receiver stalls long while full-size frames keep coming
    task automatic test_output_backpressure();
        hold_request = 400;
        repeat (2) send_frame(FR_GOOD, DEPTH);
        wait_results_drained();
    endtask

    // Frames separated by full drains
    task automatic test_pause_between_frames();
        send_frame(FR_GOOD, pick_length());
        wait_results_drained();
        send_frame(FR_BAD_SUM, pick_length());
        wait_results_drained();
        send_frame(FR_GOOD, 1);
        wait_results_drained();
    endtask

    // Mostly well-formed frames, with broken ones and line noise mixed in
    task automatic test_random_traffic(input int n_bytes);
        int start;
        int r;
        start = bytes_sent - noise_bytes;
        while (bytes_sent - noise_bytes - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_frame(FR_GOOD, pick_length());
            else if (r < 77) send_frame(FR_BAD_LEN, 0);
            else if (r < 84) send_frame(FR_BAD_SUM, pick_length());
            else if (r < 91) send_frame(FR_BAD_TAIL, pick_length());
            else send_frame(FR_NOISE, 0);
            if ($urandom_range(0, 99) < 5) wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Result receiver: random stalls, plus long holds on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                res_if.ready <= 1'b0;
                hold_request = hold_request - 1;
            end else if (idle_en) begin
                res_if.ready <= ($urandom_range(0, 99) >= 10);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare each accepted item against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got_res.status       = res_if.status;
            got_res.payload_byte = res_if.payload_byte;
            got_res.byte_index   = res_if.byte_index;
            got_res.frame_length = res_if.frame_length;
            got_res.last         = res_if.last;
            if (expected_results.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, got %h", $time, got_res);
            end else begin
                want_res = expected_results.pop_front();
                check_field("status", 8'(want_res.status), 8'(got_res.status));
                check_field("payload_byte", want_res.payload_byte, got_res.payload_byte);
                check_field("byte_index", 8'(want_res.byte_index), 8'(got_res.byte_index));
                check_field("frame_length", 8'(want_res.frame_length),
                            8'(got_res.frame_length));
                check_field("last", 8'(want_res.last), 8'(got_res.last));
                if (want_res.status) error_results++;
                else if (want_res.last) good_frames++;
                if (!want_res.status && int'(want_res.frame_length) > longest_frame)
                    longest_frame = int'(want_res.frame_length);
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("serial_frame_parser regression: fail");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n        <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        idle_en        = 1'b1;
        hold_request   = 0;
        n_fail         = 0;
        bytes_sent     = 0;
        noise_bytes    = 0;
        good_frames    = 0;
        error_results  = 0;
        longest_frame  = 0;
        quiet_cycles   = 0;
        parse_phase    = SEEK_HDR1;
        bytes_taken    = '0;
        frame_len      = '0;
        frame_sum      = '0;
        foreach (payload_copy[k]) payload_copy[k] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_backpressure();
        test_random_traffic(120);
        test_pause_between_frames();
        idle_en = 1'b0;
        test_random_traffic(60);
        idle_en = 1'b1;

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_fail += expected_results.size();
            $display("%0t: %0d expected items never arrived", $time, expected_results.size());
        end

        $display("Sent %0d bytes (%0d noise); %0d good frames, longest %0d bytes,",
                 bytes_sent, noise_bytes, good_frames, longest_frame);
        $display("and %0d frame errors, under random stalls and a long output hold.",
                 error_results);
        if (n_fail == 0) begin
            $display("serial_frame_parser regression: pass");
        end else begin
            $display("serial_frame_parser regression: fail");
        end
        $finish;
    end

endmodule
